// ----- hw/rtl/tcp_handshake_latency_tracker_top_macros.svh -----
// Assertion macros for the handshake latency tracker.
// Used by the sequencer; compiled out when SYNTHESIS is defined.
`ifndef TCP_HANDSHAKE_LATENCY_TRACKER_TOP_MACROS_SVH
`define TCP_HANDSHAKE_LATENCY_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCPHLT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcphlt assertion failed");
`define TCPHLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcphlt assertion failed");
`else
`define TCPHLT_ASSERT_NOW(label, clk, rst, ante, cons)
`define TCPHLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/tcphlt_pkg.sv -----
// Shared types and constants of the handshake latency tracker.
// No dependencies; RTL uses scoped names; the bench imports it.
package tcphlt_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  FLAG_SYN       = 8'h02;
  localparam logic [7:0]  FLAG_ACK       = 8'h10;
  localparam logic [7:0]  FLAG_SYNACK    = 8'h12;

  localparam int TIME_W = 62;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] stamp_seconds;
    logic [29:0] stamp_nanoseconds;
  } in_item_t;

  typedef struct packed {
    logic [31:0] flow_source;
    logic [31:0] flow_dest;
    logic [15:0] flow_source_port;
    logic [15:0] flow_dest_port;
    logic [31:0] syn_seconds;
    logic [29:0] syn_nanoseconds;
    logic [31:0] synack_seconds;
    logic [29:0] synack_nanoseconds;
    logic [31:0] ack_seconds;
    logic [29:0] ack_nanoseconds;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_key_t;

  // seconds in the upper 32 bits, nanoseconds in the lower 30
  typedef logic [TIME_W-1:0] stamp_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SYN,
    OP_SYNACK,
    OP_ACK
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             key_we;
    logic             syn_we;
    logic             synack_we;
    logic             set_valid;
    logic             clr_valid;
    logic [IDX_W-1:0] addr;
    flow_key_t        key;
    stamp_t           syn_time;
    stamp_t           synack_time;
  } store_wr_t;

  typedef struct packed {
    logic             live;
    logic             vld;
    logic [IDX_W-1:0] idx;
    flow_key_t        key;
    stamp_t           syn_time;
    stamp_t           synack_time;
  } store_rd_t;

endpackage

// ----- hw/rtl/tcphlt_store.sv -----
// Flow table: key and time memories with registered read, plus slot valid flops.
// Depends on tcphlt_pkg.
module tcphlt_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [tcphlt_pkg::IDX_W-1:0] rd_addr,
  input  tcphlt_pkg::store_wr_t      wr,
  output tcphlt_pkg::store_rd_t      rd
);

  tcphlt_pkg::flow_key_t key_mem    [tcphlt_pkg::ENTRIES];
  tcphlt_pkg::stamp_t    syn_mem    [tcphlt_pkg::ENTRIES];
  tcphlt_pkg::stamp_t    synack_mem [tcphlt_pkg::ENTRIES];
  logic [tcphlt_pkg::ENTRIES-1:0] slot_valid;

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.syn_we) begin
      syn_mem[wr.addr] <= wr.syn_time;
    end
    if (wr.synack_we) begin
      synack_mem[wr.addr] <= wr.synack_time;
    end
  end

  always_ff @(posedge clk) begin
    rd.key         <= key_mem[rd_addr];
    rd.syn_time    <= syn_mem[rd_addr];
    rd.synack_time <= synack_mem[rd_addr];
    rd.vld         <= slot_valid[rd_addr];
    rd.idx         <= rd_addr;
    if (rst) begin
      rd.live <= 1'b0;
    end else begin
      rd.live <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (wr.set_valid) begin
        slot_valid[wr.addr] <= 1'b1;
      end else if (wr.clr_valid) begin
        slot_valid[wr.addr] <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/tcphlt_seq.sv -----
// Sequencer: classifies a packet, walks the table through one shared key
// comparator, then updates the slot or emits the record. Uses tcphlt_pkg.
`include "tcp_handshake_latency_tracker_top_macros.svh"
module tcphlt_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tcphlt_pkg::in_item_t         item,
  output logic                         rd_en,
  output logic [tcphlt_pkg::IDX_W-1:0] rd_addr,
  input  tcphlt_pkg::store_rd_t        rd,
  output tcphlt_pkg::store_wr_t        wr,
  output logic                         result_strobe,
  output tcphlt_pkg::out_item_t        result
);

  localparam logic [tcphlt_pkg::CNT_W-1:0] CNT_END =
    tcphlt_pkg::CNT_W'(tcphlt_pkg::ENTRIES);
  localparam logic [tcphlt_pkg::IDX_W-1:0] LAST_IDX =
    tcphlt_pkg::IDX_W'(tcphlt_pkg::ENTRIES - 1);

  tcphlt_pkg::state_t             state, state_next;
  tcphlt_pkg::op_t                op, op_in;
  tcphlt_pkg::flow_key_t          skey;
  tcphlt_pkg::stamp_t             now;
  logic [tcphlt_pkg::CNT_W-1:0]   cnt;
  logic                           free_found;
  logic [tcphlt_pkg::IDX_W-1:0]   free_idx;
  logic [7:0]                     sa;
  logic                           accept, hit, last, free_any;
  logic [tcphlt_pkg::IDX_W-1:0]   free_sel;

  assign accept = start && !busy;
  assign sa     = item.tcp_flag_bits & tcphlt_pkg::FLAG_SYNACK;

  always_comb begin
    op_in = tcphlt_pkg::OP_NONE;
    if (item.ether_type == tcphlt_pkg::ETHERTYPE_IPV4 &&
        item.ip_protocol == tcphlt_pkg::PROTO_TCP) begin
      case (sa)
        tcphlt_pkg::FLAG_SYN:    op_in = tcphlt_pkg::OP_SYN;
        tcphlt_pkg::FLAG_SYNACK: op_in = tcphlt_pkg::OP_SYNACK;
        tcphlt_pkg::FLAG_ACK:    op_in = tcphlt_pkg::OP_ACK;
        default:                 op_in = tcphlt_pkg::OP_NONE;
      endcase
    end
  end

  // shared comparator on the entry read back last cycle
  assign hit      = rd.live && rd.vld && (rd.key == skey);
  assign last     = rd.live && (rd.idx == LAST_IDX);
  assign free_any = free_found || (rd.live && !rd.vld);
  assign free_sel = free_found ? free_idx : rd.idx;

  assign rd_en   = (state == tcphlt_pkg::ST_SCAN) && (cnt < CNT_END);
  assign rd_addr = cnt[tcphlt_pkg::IDX_W-1:0];
  assign busy    = (state != tcphlt_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    wr             = '0;
    wr.addr        = rd.idx;
    wr.key         = skey;
    wr.syn_time    = now;
    wr.synack_time = now;
    case (state)
      tcphlt_pkg::ST_IDLE: begin
        if (start && op_in != tcphlt_pkg::OP_NONE) begin
          state_next = tcphlt_pkg::ST_SCAN;
        end
      end
      tcphlt_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = tcphlt_pkg::ST_IDLE;
          case (op)
            tcphlt_pkg::OP_SYN: begin
              wr.syn_we      = 1'b1;
              wr.synack_we   = 1'b1;
              wr.synack_time = '0;
            end
            tcphlt_pkg::OP_SYNACK: wr.synack_we = 1'b1;
            tcphlt_pkg::OP_ACK:    wr.clr_valid = 1'b1;
            default: ;
          endcase
        end else if (last) begin
          state_next = tcphlt_pkg::ST_IDLE;
          // insert a new flow at the lowest free slot, drop when full
          if (op == tcphlt_pkg::OP_SYN && free_any) begin
            wr.addr        = free_sel;
            wr.key_we      = 1'b1;
            wr.syn_we      = 1'b1;
            wr.synack_we   = 1'b1;
            wr.synack_time = '0;
            wr.set_valid   = 1'b1;
          end
        end
      end
      default: state_next = tcphlt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcphlt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      op         <= tcphlt_pkg::OP_NONE;
      free_found <= 1'b0;
    end else if (accept) begin
      cnt        <= '0;
      op         <= op_in;
      free_found <= 1'b0;
    end else if (state == tcphlt_pkg::ST_SCAN) begin
      if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
      if (rd.live && !rd.vld && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now <= {item.stamp_seconds, item.stamp_nanoseconds};
      if (op_in == tcphlt_pkg::OP_SYNACK) begin
        skey <= '{src: item.dest_address, dst: item.source_address,
                  sport: item.dest_port, dport: item.source_port};
      end else begin
        skey <= '{src: item.source_address, dst: item.dest_address,
                  sport: item.source_port, dport: item.dest_port};
      end
    end
    if (state == tcphlt_pkg::ST_SCAN && rd.live && !rd.vld && !free_found) begin
      free_idx <= rd.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == tcphlt_pkg::ST_SCAN) && hit &&
                       (op == tcphlt_pkg::OP_ACK);
    end
  end

  always_ff @(posedge clk) begin
    result.flow_source        <= rd.key.src;
    result.flow_dest          <= rd.key.dst;
    result.flow_source_port   <= rd.key.sport;
    result.flow_dest_port     <= rd.key.dport;
    result.syn_seconds        <= rd.syn_time[61:30];
    result.syn_nanoseconds    <= rd.syn_time[29:0];
    result.synack_seconds     <= rd.synack_time[61:30];
    result.synack_nanoseconds <= rd.synack_time[29:0];
    result.ack_seconds        <= now[61:30];
    result.ack_nanoseconds    <= now[29:0];
  end

  `TCPHLT_ASSERT_NOW(a_strobe_after_scan, clk, rst, result_strobe, $past(state == tcphlt_pkg::ST_SCAN))
  `TCPHLT_ASSERT_NOW(a_strobe_only_ack, clk, rst, result_strobe, $past(op == tcphlt_pkg::OP_ACK))
  `TCPHLT_ASSERT_NEXT(a_acted_goes_busy, clk, rst, accept && op_in != tcphlt_pkg::OP_NONE, busy)
  `TCPHLT_ASSERT_NOW(a_cnt_in_range, clk, rst, state == tcphlt_pkg::ST_SCAN, cnt <= CNT_END)
  `TCPHLT_ASSERT_NOW(a_one_valid_op, clk, rst, wr.set_valid, !wr.clr_valid && !hit)

endmodule

// ----- hw/rtl/tcp_handshake_latency_tracker_top.sv -----
// TCP handshake latency tracker, top level.
// Uses tcphlt_pkg, tcphlt_store and tcphlt_seq.
//
// Input channel: present a packet on item and raise start; it is taken at a
// rising edge where start is high and busy is low. busy is high while the
// table is walked. Packets that are not IPv4 TCP, or carry neither SYN nor
// ACK, are taken without raising busy.
// A SYN, SYN-ACK or ACK walks the flow table one slot a cycle through the
// shared key comparator, fed by the registered read port of the key memory.
// A hit ends the walk at the matching slot; a miss walks all ENTRIES slots.
// The next packet is taken only after the walk ends, so a miss, which walks
// the whole table, sets the packet rate.
// Output channel: a completed handshake record appears on result for
// exactly one cycle with result_strobe high, in the cycle after the hit. The
// receiver cannot stall; each record must be taken in that cycle.
// Reset (rst, synchronous) empties the table by clearing the slot valid
// flops together; no clearing pass runs.
module tcp_handshake_latency_tracker_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tcphlt_pkg::in_item_t  item,
  output logic                  result_strobe,
  output tcphlt_pkg::out_item_t result
);

  logic                         rd_en;
  logic [tcphlt_pkg::IDX_W-1:0] rd_addr;
  tcphlt_pkg::store_rd_t        rd;
  tcphlt_pkg::store_wr_t        wr;

  tcphlt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  tcphlt_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd            (rd),
    .wr            (wr),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

// ----- test/testbench.sv -----
// Testbench for tcp_handshake_latency_tracker_top: drives handshake traffic and
// checks every latency record against a flow-table model kept here.
// Depends on tcphlt_pkg and the tracker RTL.
module testbench;
  import tcphlt_pkg::*;

  localparam logic [15:0] ETHERTYPE_IPV4_SWAPPED = 16'h0008;
  localparam logic [7:0]  PROTO_UDP              = 8'd17;
  localparam int          OPEN_FLOW_CAP          = 48;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    item;
  logic        result_strobe;
  out_item_t   result;

  in_item_t    packets_pending [$];
  out_item_t   records_due [$];
  flow_key_t   open_flows [$];
  int          beats_sent = 0;
  int          beats_taken = 0;
  int          sender_idle_pct = 0;
  bit          run_failed = 1'b0;

  // flow table as the tracker should hold it
  bit          slot_live [ENTRIES];
  flow_key_t   slot_key [ENTRIES];
  stamp_t      slot_syn [ENTRIES];
  stamp_t      slot_synack [ENTRIES];

  tcp_handshake_latency_tracker_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #1 clk = ~clk;

  function automatic flow_key_t flip_flow(flow_key_t k);
    return {k.dst, k.src, k.dport, k.sport};
  endfunction

  function automatic int find_flow(flow_key_t k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_live[i]) return i;
    end
    return -1;
  endfunction

  task automatic track_packet(in_item_t p);
    flow_key_t k;
    stamp_t    now;
    logic [7:0] sa;
    int        s;
    out_item_t r;
    if (p.ether_type != ETHERTYPE_IPV4 || p.ip_protocol != PROTO_TCP) return;
    k   = {p.source_address, p.dest_address, p.source_port, p.dest_port};
    now = {p.stamp_seconds, p.stamp_nanoseconds};
    sa  = p.tcp_flag_bits & FLAG_SYNACK;
    case (sa)
      FLAG_SYN: begin
        s = find_flow(k);
        if (s < 0) begin
          s = first_free_slot();
          // table full: drop the new flow
          if (s < 0) return;
          slot_live[s] = 1'b1;
          slot_key[s]  = k;
        end
        slot_syn[s]    = now;
        slot_synack[s] = '0;
      end
      FLAG_SYNACK: begin
        s = find_flow(flip_flow(k));
        if (s >= 0) slot_synack[s] = now;
      end
      FLAG_ACK: begin
        s = find_flow(k);
        if (s >= 0) begin
          r.flow_source        = slot_key[s].src;
          r.flow_dest          = slot_key[s].dst;
          r.flow_source_port   = slot_key[s].sport;
          r.flow_dest_port     = slot_key[s].dport;
          r.syn_seconds        = slot_syn[s][TIME_W-1:30];
          r.syn_nanoseconds    = slot_syn[s][29:0];
          r.synack_seconds     = slot_synack[s][TIME_W-1:30];
          r.synack_nanoseconds = slot_synack[s][29:0];
          r.ack_seconds        = p.stamp_seconds;
          r.ack_nanoseconds    = p.stamp_nanoseconds;
          records_due.push_back(r);
          slot_live[s] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      run_failed = 1'b1;
    end
  endtask

  task automatic check_record(out_item_t got);
    out_item_t want;
    if (records_due.size() == 0) begin
      $error("record for flow %h:%h -> %h:%h with none expected", got.flow_source,
             got.flow_source_port, got.flow_dest, got.flow_dest_port);
      run_failed = 1'b1;
      return;
    end
    want = records_due.pop_front();
    compare_field("flow_source", want.flow_source, got.flow_source);
    compare_field("flow_dest", want.flow_dest, got.flow_dest);
    compare_field("flow_source_port", 32'(want.flow_source_port),
                  32'(got.flow_source_port));
    compare_field("flow_dest_port", 32'(want.flow_dest_port),
                  32'(got.flow_dest_port));
    compare_field("syn_seconds", want.syn_seconds, got.syn_seconds);
    compare_field("syn_nanoseconds", 32'(want.syn_nanoseconds),
                  32'(got.syn_nanoseconds));
    compare_field("synack_seconds", want.synack_seconds, got.synack_seconds);
    compare_field("synack_nanoseconds", 32'(want.synack_nanoseconds),
                  32'(got.synack_nanoseconds));
    compare_field("ack_seconds", want.ack_seconds, got.ack_seconds);
    compare_field("ack_nanoseconds", 32'(want.ack_nanoseconds),
                  32'(got.ack_nanoseconds));
  endtask

  // Driver: present the next packet at the falling edge, hold while not taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && beats_taken != beats_sent) begin
        // hold the beat
      end else if (packets_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        beats_sent++;
        item  <= packets_pending.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check records first, then predict from the packet taken this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) check_record(result);
      if (start && !busy) begin
        track_packet(item);
        beats_taken++;
      end
    end
  end

  function automatic flow_key_t fresh_flow();
    flow_key_t k;
    k = {$urandom, $urandom, $urandom};
    // tiny values make symmetric and colliding tuples likely
    if ($urandom_range(7) == 0) begin
      k.src   = 32'($urandom_range(3));
      k.dst   = 32'($urandom_range(3));
      k.sport = 16'($urandom_range(3));
      k.dport = 16'($urandom_range(3));
    end
    return k;
  endfunction

  function automatic in_item_t tcp_packet(logic [7:0] flags, flow_key_t k);
    in_item_t p;
    p.ether_type        = ETHERTYPE_IPV4;
    p.ip_protocol       = PROTO_TCP;
    p.tcp_flag_bits     = flags;
    p.source_address    = k.src;
    p.dest_address      = k.dst;
    p.source_port       = k.sport;
    p.dest_port         = k.dport;
    p.stamp_seconds     = $urandom;
    p.stamp_nanoseconds = 30'($urandom);
    return p;
  endfunction

  task automatic queue_tcp(logic [7:0] flags, flow_key_t k);
    packets_pending.push_back(tcp_packet(flags, k));
  endtask

  function automatic logic [7:0] syn_flags();
    if ($urandom_range(3) == 0) return FLAG_SYN;
    return (8'($urandom) & ~FLAG_ACK) | FLAG_SYN;
  endfunction

  function automatic logic [7:0] synack_flags();
    if ($urandom_range(3) == 0) return FLAG_SYNACK;
    return 8'($urandom) | FLAG_SYNACK;
  endfunction

  function automatic logic [7:0] ack_flags();
    if ($urandom_range(3) == 0) return FLAG_ACK;
    return (8'($urandom) & ~FLAG_SYN) | FLAG_ACK;
  endfunction

  function automatic in_item_t noise_packet();
    in_item_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, 30'($urandom)};
    case ($urandom_range(2))
      0: if (p.ether_type == ETHERTYPE_IPV4) p.ether_type = ETHERTYPE_IPV4_SWAPPED;
      1: begin
        p.ether_type = ETHERTYPE_IPV4;
        if (p.ip_protocol == PROTO_TCP) p.ip_protocol = ~PROTO_TCP;
      end
      default: begin
        p.ether_type    = ETHERTYPE_IPV4;
        p.ip_protocol   = PROTO_TCP;
        p.tcp_flag_bits = p.tcp_flag_bits & ~FLAG_SYNACK;
      end
    endcase
    return p;
  endfunction

  task automatic queue_directed();
    flow_key_t a, b, c, d, e;
    in_item_t  p;
    a = {32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0};
    b = '0;
    c = fresh_flow();
    d = fresh_flow();
    e = fresh_flow();
    // other traffic and flagless TCP do nothing
    p = tcp_packet(FLAG_SYN, a);
    p.ether_type = ETHERTYPE_IPV4_SWAPPED;
    packets_pending.push_back(p);
    p.ether_type = 16'hFFFF;
    packets_pending.push_back(p);
    p = tcp_packet(FLAG_SYN, a);
    p.ip_protocol = PROTO_UDP;
    packets_pending.push_back(p);
    queue_tcp(~FLAG_SYNACK, a);
    // misses on an empty table
    queue_tcp(FLAG_ACK, a);
    queue_tcp(FLAG_SYNACK, flip_flow(a));
    p = tcp_packet(FLAG_SYN, a);
    p.stamp_seconds     = '1;
    p.stamp_nanoseconds = '1;
    packets_pending.push_back(p);
    queue_tcp(8'hFF, a);
    p = tcp_packet(FLAG_SYNACK, flip_flow(a));
    p.stamp_seconds     = '0;
    p.stamp_nanoseconds = 30'd999_999_999;
    packets_pending.push_back(p);
    queue_tcp(FLAG_ACK, flip_flow(a));
    queue_tcp(~FLAG_SYN, a);
    queue_tcp(FLAG_ACK, a);
    // symmetric flow; repeated SYN clears the SYN-ACK time
    p = tcp_packet(~FLAG_ACK, b);
    p.stamp_seconds     = '0;
    p.stamp_nanoseconds = '0;
    packets_pending.push_back(p);
    queue_tcp(FLAG_SYNACK, b);
    queue_tcp(FLAG_SYN, b);
    p = tcp_packet(FLAG_ACK, b);
    p.stamp_nanoseconds = 30'd1_000_000_000;
    packets_pending.push_back(p);
    // freed slot is reused lowest first
    queue_tcp(FLAG_SYN, c);
    queue_tcp(FLAG_SYN, d);
    queue_tcp(FLAG_ACK, c);
    queue_tcp(FLAG_SYN, e);
    queue_tcp(FLAG_ACK, d);
    queue_tcp(FLAG_ACK, e);
  endtask

  task automatic queue_random_traffic(int n);
    int        counted;
    int        pick;
    int        r;
    flow_key_t k;
    counted = 0;
    while (counted < n) begin
      r = int'($urandom_range(99));
      if (open_flows.size() == 0 || (r < 25 && open_flows.size() < OPEN_FLOW_CAP)) begin
        k = fresh_flow();
        open_flows.push_back(k);
        queue_tcp(syn_flags(), k);
        counted++;
      end else if (r >= 88) begin
        packets_pending.push_back(noise_packet());
      end else begin
        pick = int'($urandom_range(open_flows.size() - 1));
        k = open_flows[pick];
        counted++;
        if (r < 45) begin
          queue_tcp(synack_flags(), flip_flow(k));
        end else if (r < 70) begin
          queue_tcp(ack_flags(), k);
          open_flows.delete(pick);
        end else if (r < 78) begin
          queue_tcp(syn_flags(), k);
        end else begin
          // broken sequences: one bit off, or the wrong direction
          case ($urandom_range(2))
            0: begin
              k[$urandom_range(95)] ^= 1'b1;
              queue_tcp(ack_flags(), k);
            end
            1: begin
              k[$urandom_range(95)] ^= 1'b1;
              queue_tcp(synack_flags(), flip_flow(k));
            end
            default: queue_tcp(ack_flags(), flip_flow(k));
          endcase
        end
      end
    end
  endtask

  task automatic queue_table_fill();
    flow_key_t filled [$];
    flow_key_t k;
    int        i;
    while (open_flows.size() > 0) queue_tcp(ack_flags(), open_flows.pop_front());
    for (i = 0; i < ENTRIES + 3; i++) begin
      k = {$urandom, $urandom, $urandom};
      k.dport = 16'(i);
      queue_tcp(syn_flags(), k);
      if (i < ENTRIES) filled.push_back(k);
    end
    // the last overflow SYN was dropped, so its SYN-ACK and ACK miss
    queue_tcp(synack_flags(), flip_flow(k));
    queue_tcp(ack_flags(), k);
    // a stored flow still takes a repeated SYN while full
    queue_tcp(syn_flags(), filled[ENTRIES - 1]);
    for (i = 0; i < ENTRIES; i += 3) queue_tcp(synack_flags(), flip_flow(filled[i]));
    while (filled.size() > 0) begin
      i = int'($urandom_range(filled.size() - 1));
      queue_tcp(ack_flags(), filled[i]);
      filled.delete(i);
      if (filled.size() == ENTRIES / 2) begin
        k = fresh_flow();
        open_flows.push_back(k);
        queue_tcp(syn_flags(), k);
      end
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    queue_directed();
    queue_random_traffic(280);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the receiver cannot hold records off, so only the sender idles
    do @(posedge clk); while (packets_pending.size() != 0);
    sender_idle_pct = 67;
    queue_random_traffic(280);
    do @(posedge clk); while (packets_pending.size() != 0);
    sender_idle_pct = 15;
    queue_table_fill();
    queue_random_traffic(200);
    do @(posedge clk); while (packets_pending.size() != 0 || beats_taken != beats_sent);
    do @(posedge clk); while (records_due.size() != 0);
    repeat (ENTRIES + 8) @(posedge clk);
    if (run_failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $error("timeout with %0d packets pending, %0d records due",
           packets_pending.size(), records_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- tcp_handshake_latency_tracker_top.f -----
+incdir+hw/rtl
hw/rtl/tcphlt_pkg.sv
hw/rtl/tcphlt_store.sv
hw/rtl/tcphlt_seq.sv
hw/rtl/tcp_handshake_latency_tracker_top.sv
test/testbench.sv
